// ===== rtl/core/lpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants for the length-prefixed frame decoder.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

  // Header byte offsets (big-endian fields)
  localparam logic [HDR_IDX_W-1:0] OFS_VERSION  = HDR_IDX_W'(4);
  localparam logic [HDR_IDX_W-1:0] OFS_TYPE     = HDR_IDX_W'(6);
  localparam logic [HDR_IDX_W-1:0] OFS_FLAGS    = HDR_IDX_W'(8);
  localparam logic [HDR_IDX_W-1:0] OFS_RESERVED = HDR_IDX_W'(10);
  localparam logic [HDR_IDX_W-1:0] OFS_SEQ      = HDR_IDX_W'(12);
  localparam logic [HDR_IDX_W-1:0] OFS_LENGTH   = HDR_IDX_W'(16);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HEADER_BYTES - 1);

  // Result kinds
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_BODY = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_MAGIC   = 2'd0;
  localparam logic [1:0] ERR_VERSION = 2'd1;
  localparam logic [1:0] ERR_LENGTH  = 2'd2;
  localparam logic [1:0] ERR_TYPE    = 2'd3;

  // Register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_MAX = 3'd4;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [15:0] expected_version;
    logic [31:0] max_body_len;
    logic [15:0] type_min;
    logic [15:0] type_max;
  } lpfd_cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] msg_type;
    logic [15:0] msg_flags;
    logic [31:0] seq_num;
    logic [31:0] body_len;
    logic [7:0]  data_byte;
    logic        last;
    logic [1:0]  error_code;
  } lpfd_res_t;

endpackage

// ===== rtl/core/lpfd_front.sv =====
// ----------------------------------------------------------------------------
// lpfd_front
// Byte parser: collects the header, runs the checks, tags body bytes and
// pushes one result record per producing byte into the result queue.
// ----------------------------------------------------------------------------
module lpfd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         in_byte,
  input  lpfd_pkg::lpfd_cfg_t cfg,
  output logic               push,
  output lpfd_pkg::lpfd_res_t push_rec
);
  import lpfd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_DEAD
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [HDR_IDX_W-1:0]   hdr_idx_r, hdr_idx_nxt;
  logic [31:0]            magic_r, magic_nxt;
  logic [15:0]            version_r, version_nxt;
  logic [15:0]            type_r, type_nxt;
  logic [15:0]            flags_r, flags_nxt;
  logic [31:0]            seq_r, seq_nxt;
  logic [31:0]            length_r, length_nxt;
  logic [31:0]            body_rem_r, body_rem_nxt;
  logic [31:0]            rem_dec;
  logic                   err_hit;
  logic [1:0]             err_code;
  logic                   has_res;
  lpfd_res_t              rec;

  // Field capture: shift the byte into whichever field the index points at
  always_comb begin
    magic_nxt   = magic_r;
    version_nxt = version_r;
    type_nxt    = type_r;
    flags_nxt   = flags_r;
    seq_nxt     = seq_r;
    length_nxt  = length_r;
    if (hdr_idx_r < OFS_VERSION) begin
      magic_nxt = {magic_r[23:0], in_byte};
    end else if (hdr_idx_r < OFS_TYPE) begin
      version_nxt = {version_r[7:0], in_byte};
    end else if (hdr_idx_r < OFS_FLAGS) begin
      type_nxt = {type_r[7:0], in_byte};
    end else if (hdr_idx_r < OFS_RESERVED) begin
      flags_nxt = {flags_r[7:0], in_byte};
    end else if (hdr_idx_r < OFS_SEQ) begin
      // reserved field, dropped
    end else if (hdr_idx_r < OFS_LENGTH) begin
      seq_nxt = {seq_r[23:0], in_byte};
    end else begin
      length_nxt = {length_r[23:0], in_byte};
    end
  end

  // Header checks, first failure wins
  always_comb begin
    err_hit  = 1'b1;
    err_code = ERR_MAGIC;
    if (magic_nxt != cfg.expected_magic) begin
      err_code = ERR_MAGIC;
    end else if (version_nxt != cfg.expected_version) begin
      err_code = ERR_VERSION;
    end else if (length_nxt > cfg.max_body_len) begin
      err_code = ERR_LENGTH;
    end else if (type_nxt < cfg.type_min || type_nxt > cfg.type_max) begin
      err_code = ERR_TYPE;
    end else begin
      err_hit = 1'b0;
    end
  end

  assign rem_dec = body_rem_r - 32'd1;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_idx_nxt  = hdr_idx_r;
    body_rem_nxt = body_rem_r;
    has_res      = 1'b0;
    rec          = '0;
    unique case (phase_r)
      PH_HEADER: begin
        if (hdr_idx_r == HDR_LAST_IDX) begin
          hdr_idx_nxt = '0;
          has_res     = 1'b1;
          if (err_hit) begin
            rec.kind       = KIND_ERR;
            rec.last       = 1'b1;
            rec.error_code = err_code;
            phase_nxt      = PH_DEAD;
          end else begin
            rec.kind      = KIND_HDR;
            rec.msg_type  = type_nxt;
            rec.msg_flags = flags_nxt;
            rec.seq_num   = seq_nxt;
            rec.body_len  = length_nxt;
            if (length_nxt == 32'd0) begin
              rec.last = 1'b1;
            end else begin
              body_rem_nxt = length_nxt;
              phase_nxt    = PH_BODY;
            end
          end
        end else begin
          hdr_idx_nxt = hdr_idx_r + HDR_IDX_W'(1);
        end
      end
      PH_BODY: begin
        has_res       = 1'b1;
        rec.kind      = KIND_BODY;
        rec.data_byte = in_byte;
        body_rem_nxt  = rem_dec;
        if (rem_dec == 32'd0) begin
          rec.last    = 1'b1;
          phase_nxt   = PH_HEADER;
          hdr_idx_nxt = '0;
        end
      end
      PH_DEAD: begin
        // stream is dropped until reset
      end
      default: begin
        phase_nxt = PH_DEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_idx_r  <= '0;
      magic_r    <= '0;
      version_r  <= '0;
      type_r     <= '0;
      flags_r    <= '0;
      seq_r      <= '0;
      length_r   <= '0;
      body_rem_r <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      body_rem_r <= body_rem_nxt;
      if (phase_r == PH_HEADER) begin
        magic_r   <= magic_nxt;
        version_r <= version_nxt;
        type_r    <= type_nxt;
        flags_r   <= flags_nxt;
        seq_r     <= seq_nxt;
        length_r  <= length_nxt;
      end
    end
  end

  assign push     = fire && has_res;
  assign push_rec = rec;

  a_dead_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DEAD |-> !push)
    else $error("result pushed after error");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_idx_r <= HDR_LAST_IDX)
    else $error("header index out of range");

  a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> body_rem_r != 32'd0)
    else $error("body phase with nothing left");

endmodule

// ===== rtl/core/lpfd_queue.sv =====
// ----------------------------------------------------------------------------
// lpfd_queue
// Small result queue between parser and output stage.
// ----------------------------------------------------------------------------
module lpfd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpfd_pkg::lpfd_res_t push_rec,
  output logic                full,
  output logic                not_empty,
  input  logic                pop,
  output lpfd_pkg::lpfd_res_t pop_rec
);
  import lpfd_pkg::*;

  lpfd_res_t         mem_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r;
  logic [QAW-1:0]    rd_ptr_r;
  logic [QAW:0]      cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QAW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QAW+1)'(1);
      end
    end
  end

  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_rec   = mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop)
    else $error("pop from empty queue");

endmodule

// ===== rtl/core/lpfd_back.sv =====
// ----------------------------------------------------------------------------
// lpfd_back
// Output stage: pulls result records from the queue into the output
// register and holds them until the receiver takes them.
// ----------------------------------------------------------------------------
module lpfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  lpfd_pkg::lpfd_res_t q_rec,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lpfd_pkg::lpfd_res_t out_rec
);
  import lpfd_pkg::*;

  logic      out_valid_r;
  lpfd_res_t out_rec_r;

  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_rec_r <= q_rec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

endmodule

// ===== rtl/core/length_prefixed_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder
// Parses a byte stream of 20-byte big-endian headers plus bodies.
//
// Input channel in_valid/in_ready/in_byte carries one stream byte per
// transaction. Result channel out_* carries a header result (kind 0), one
// body byte (kind 1) or an error (kind 2); out_last marks the final result
// of a packet. Header fields are checked against cfg registers when the last
// header byte arrives: magic, version, body limit, then the type range.
// After an error every further byte is taken and dropped until reset.
// Throughput: one byte per cycle while the result queue is not full. Each
// result is written into the queue at the edge that accepts its byte, then
// loaded in queue order into the output register when it is empty or read.
// A four-entry result queue sits between the parser and the output register;
// in_ready drops only when that queue is full, so a stalled receiver leaves
// five results held (four queued, one in the output register) before input
// stops. Reset (synchronous, rst_n low) returns the registers to their
// defaults, restarts header collection and empties the queue. Configuration
// writes take effect on the next cycle and are meant for idle periods.
// ----------------------------------------------------------------------------
module length_prefixed_frame_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [15:0]                   out_msg_type,
  output logic [15:0]                   out_msg_flags,
  output logic [31:0]                   out_seq_num,
  output logic [31:0]                   out_body_len,
  output logic [7:0]                    out_data_byte,
  output logic                          out_last,
  output logic [1:0]                    out_error_code,
  input  logic                          cfg_we,
  input  logic [lpfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import lpfd_pkg::*;

  lpfd_cfg_t cfg_r;
  logic      fire;
  logic      push;
  lpfd_res_t push_rec;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;
  lpfd_res_t q_rec;
  lpfd_res_t out_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_magic   <= 32'd0;
      cfg_r.expected_version <= 16'd1;
      cfg_r.max_body_len     <= 32'd65536;
      cfg_r.type_min         <= 16'd0;
      cfg_r.type_max         <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAGIC:    cfg_r.expected_magic   <= cfg_wdata;
        REG_VERSION:  cfg_r.expected_version <= cfg_wdata[15:0];
        REG_MAX_BODY: cfg_r.max_body_len     <= cfg_wdata;
        REG_TYPE_MIN: cfg_r.type_min         <= cfg_wdata[15:0];
        REG_TYPE_MAX: cfg_r.type_max         <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  lpfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .in_byte  (in_byte),
    .cfg      (cfg_r),
    .push     (push),
    .push_rec (push_rec)
  );

  lpfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_rec   (q_rec)
  );

  lpfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rec       (q_rec),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rec     (out_rec)
  );

  assign out_kind       = out_rec.kind;
  assign out_msg_type   = out_rec.msg_type;
  assign out_msg_flags  = out_rec.msg_flags;
  assign out_seq_num    = out_rec.seq_num;
  assign out_body_len   = out_rec.body_len;
  assign out_data_byte  = out_rec.data_byte;
  assign out_last       = out_rec.last;
  assign out_error_code = out_rec.error_code;

endmodule

// ===== bench/tb_length_prefixed_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_length_prefixed_frame_decoder
// Self-checking bench for the frame decoder. Frames are built as 20-byte
// big-endian headers plus random bodies and streamed in with bursty input
// and a stalling receiver. A byte-level decoder in the bench predicts the
// header, body and error results not written out directly, and a scoreboard
// checks each result field by field. Register settings change between runs
// of frames; the run ends on a single broken header, then bytes to be dropped.
// ----------------------------------------------------------------------------
module tb_length_prefixed_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import lpfd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 155;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(REG_TYPE_MAX + 1);

  typedef enum logic [1:0] {DEC_HEADER, DEC_BODY, DEC_DEAD} dec_phase_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] typ;
    logic [15:0] flags;
    logic [15:0] rsvd;
    logic [31:0] seq;
    logic [31:0] len;
  } frame_hdr_t;

  // Directed frames under the reset register values (magic 0, version 1).
  localparam frame_hdr_t DIRECTED_FRAMES [4] = '{
    '{32'h0, 16'h1, 16'h0,    16'h0,    16'h0,    32'h0,         32'h0},
    '{32'h0, 16'h1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0},
    '{32'h0, 16'h1, 16'h8001, 16'h0180, 16'h5A5A, 32'h8000_0001, 32'h1},
    '{32'h0, 16'h1, 16'h1234, 16'h00FF, 16'h0,    32'h0000_0002, 32'h3}
  };
  // Rows whose header result is written out directly.
  localparam bit [3:0] DIRECTED_TYPED = 4'b0111;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_kind;
  logic [15:0]          out_msg_type;
  logic [15:0]          out_msg_flags;
  logic [31:0]          out_seq_num;
  logic [31:0]          out_body_len;
  logic [7:0]           out_data_byte;
  logic                 out_last;
  logic [1:0]           out_error_code;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = 32'h0;

  length_prefixed_frame_decoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_msg_type  (out_msg_type),
    .out_msg_flags (out_msg_flags),
    .out_seq_num   (out_seq_num),
    .out_body_len  (out_body_len),
    .out_data_byte (out_data_byte),
    .out_last      (out_last),
    .out_error_code(out_error_code),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Decoder shadow state
  lpfd_cfg_t   dec_cfg;
  dec_phase_t  dec_phase = DEC_HEADER;
  int          hdr_pos = 0;
  logic [31:0] acc_magic = '0;
  logic [15:0] acc_version = '0;
  logic [15:0] acc_type = '0;
  logic [15:0] acc_flags = '0;
  logic [31:0] acc_seq = '0;
  logic [31:0] acc_len = '0;
  logic [31:0] body_left = '0;

  lpfd_res_t   pending_results[$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  bit          draining = 1'b0;

  // Returns 1 when the byte produces a result.
  function automatic bit decode_byte(input logic [7:0] b, output lpfd_res_t r);
    logic [1:0] code;
    bit         bad;
    r = '0;
    bad = 1'b0;
    code = ERR_MAGIC;
    if (dec_phase == DEC_DEAD) return 1'b0;
    if (dec_phase == DEC_BODY) begin
      r.kind = KIND_BODY;
      r.data_byte = b;
      body_left = body_left - 1;
      if (body_left == 0) begin
        r.last = 1'b1;
        dec_phase = DEC_HEADER;
        hdr_pos = 0;
      end
      return 1'b1;
    end
    if (hdr_pos < OFS_VERSION) acc_magic = {acc_magic[23:0], b};
    else if (hdr_pos < OFS_TYPE) acc_version = {acc_version[7:0], b};
    else if (hdr_pos < OFS_FLAGS) acc_type = {acc_type[7:0], b};
    else if (hdr_pos < OFS_RESERVED) acc_flags = {acc_flags[7:0], b};
    else if (hdr_pos < OFS_SEQ) ;  // reserved, dropped
    else if (hdr_pos < OFS_LENGTH) acc_seq = {acc_seq[23:0], b};
    else acc_len = {acc_len[23:0], b};
    if (hdr_pos + 1 < HEADER_BYTES) begin
      hdr_pos++;
      return 1'b0;
    end
    hdr_pos = 0;
    // checks in priority order
    if (acc_magic != dec_cfg.expected_magic) begin
      bad = 1'b1; code = ERR_MAGIC;
    end else if (acc_version != dec_cfg.expected_version) begin
      bad = 1'b1; code = ERR_VERSION;
    end else if (acc_len > dec_cfg.max_body_len) begin
      bad = 1'b1; code = ERR_LENGTH;
    end else if (acc_type < dec_cfg.type_min || acc_type > dec_cfg.type_max) begin
      bad = 1'b1; code = ERR_TYPE;
    end
    if (bad) begin
      r.kind = KIND_ERR;
      r.last = 1'b1;
      r.error_code = code;
      dec_phase = DEC_DEAD;
      return 1'b1;
    end
    r.kind = KIND_HDR;
    r.msg_type = acc_type;
    r.msg_flags = acc_flags;
    r.seq_num = acc_seq;
    r.body_len = acc_len;
    if (acc_len == 0) r.last = 1'b1;
    else begin
      body_left = acc_len;
      dec_phase = DEC_BODY;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Result scoreboard
  always @(posedge clk) begin
    lpfd_res_t got_res;
    lpfd_res_t want_res;
    if (rst_n && out_valid && out_ready) begin
      got_res = {out_kind, out_msg_type, out_msg_flags, out_seq_num, out_body_len,
                 out_data_byte, out_last, out_error_code};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(got_res.kind), 32'h0);
      end else begin
        want_res = pending_results.pop_front();
        check_field("kind", 32'(got_res.kind), 32'(want_res.kind));
        check_field("msg_type", 32'(got_res.msg_type), 32'(want_res.msg_type));
        check_field("msg_flags", 32'(got_res.msg_flags), 32'(want_res.msg_flags));
        check_field("seq_num", got_res.seq_num, want_res.seq_num);
        check_field("body_len", got_res.body_len, want_res.body_len);
        check_field("data_byte", 32'(got_res.data_byte), 32'(want_res.data_byte));
        check_field("last", 32'(got_res.last), 32'(want_res.last));
        check_field("error_code", 32'(got_res.error_code), 32'(want_res.error_code));
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_length_prefixed_frame_decoder: FAIL");
      $finish;
    end
  end

  // Receiver backpressure: the mode and its run length are drawn at random
  int          rx_mode = 0;
  int          rx_mode_left = 0;
  logic [31:0] rx_mask = '1;

  always @(negedge clk) begin
    if (draining) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(16, 96);
        rx_mask = $urandom;
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: begin
          out_ready <= rx_mask[0];
          rx_mask = {rx_mask[0], rx_mask[31:1]};
        end
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit use_typed,
                           input lpfd_res_t typed_res);
    lpfd_res_t r;
    if (burst_left == 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (decode_byte(b, r))
      pending_results.insert(pending_results.size(), use_typed ? typed_res : r);
  endtask

  // Header bytes, then body bytes for as long as the decoder expects them.
  task automatic send_frame(input frame_hdr_t h, input bit typed,
                            input lpfd_res_t typed_res);
    for (int i = 0; i < HEADER_BYTES; i++)
      send_byte(h[159 - 8*i -: 8], typed && (i == HEADER_BYTES - 1), typed_res);
    while (dec_phase == DEC_BODY) send_byte(8'($urandom), 1'b0, '0);
  endtask

  function automatic frame_hdr_t random_frame();
    frame_hdr_t  f;
    logic [31:0] cap;
    cap = (dec_cfg.max_body_len < 40) ? dec_cfg.max_body_len : 32'd40;
    f.magic = dec_cfg.expected_magic;
    f.version = dec_cfg.expected_version;
    f.typ = 16'($urandom_range(dec_cfg.type_min, dec_cfg.type_max));
    f.flags = 16'($urandom);
    f.rsvd = 16'($urandom);
    f.seq = $urandom;
    f.len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cap)
                                        : $urandom_range(0, (cap < 8) ? cap : 8);
    return f;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_MAGIC:    dec_cfg.expected_magic = data;
      REG_VERSION:  dec_cfg.expected_version = data[15:0];
      REG_MAX_BODY: dec_cfg.max_body_len = data;
      REG_TYPE_MIN: dec_cfg.type_min = data[15:0];
      REG_TYPE_MAX: dec_cfg.type_max = data[15:0];
      default: ;
    endcase
  endtask

  // Drop valid, let the decoder finish and flush its results.
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(input int p);
    logic [31:0] magic;
    logic [31:0] limit;
    logic [15:0] ver;
    logic [15:0] t_lo;
    logic [15:0] t_hi;
    logic [15:0] t_a;
    logic [15:0] t_b;
    magic = $urandom;
    ver = 16'($urandom);
    case (p)
      0: begin
        magic = '1; ver = '1; limit = '1; t_lo = 16'h0000; t_hi = 16'hFFFF;
      end
      1: begin
        // zero-length bodies only
        magic = '0; ver = '0; limit = '0; t_lo = 16'h0000; t_hi = 16'h0000;
      end
      2: begin
        limit = $urandom_range(1, 64); t_lo = 16'hFFFF; t_hi = 16'hFFFF;
      end
      3: begin
        limit = $urandom;
        t_a = 16'($urandom);
        t_b = 16'($urandom);
        t_lo = (t_a < t_b) ? t_a : t_b;
        t_hi = (t_a < t_b) ? t_b : t_a;
      end
      default: begin
        limit = 32'd16; t_lo = 16'($urandom); t_hi = t_lo;
      end
    endcase
    write_reg(REG_MAGIC, magic);
    write_reg(REG_VERSION, {16'($urandom), ver});
    write_reg(REG_MAX_BODY, limit);
    write_reg(REG_TYPE_MIN, {16'($urandom), t_lo});
    write_reg(REG_TYPE_MAX, {16'($urandom), t_hi});
    // out-of-range index last, so any aliasing would corrupt a live register
    write_reg(CFG_IDX_W'(REG_FIRST_UNUSED + $urandom_range(0, 2)), $urandom);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  initial begin
    lpfd_res_t   hdr_res;
    lpfd_res_t   err_res;
    frame_hdr_t  h;
    int          target;
    int          scenario;
    logic [15:0] t_lo;
    dec_cfg.expected_magic = 32'h0;
    dec_cfg.expected_version = 16'h1;
    dec_cfg.max_body_len = 32'd65536;
    dec_cfg.type_min = 16'h0000;
    dec_cfg.type_max = 16'hFFFF;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Ignored write to an unused index before the directed frames.
    write_reg(REG_FIRST_UNUSED, 32'hFFFF_FFFF);
    @(negedge clk) cfg_we <= 1'b0;

    for (int i = 0; i < 4; i++) begin
      hdr_res = '0;
      hdr_res.kind = KIND_HDR;
      hdr_res.msg_type = DIRECTED_FRAMES[i].typ;
      hdr_res.msg_flags = DIRECTED_FRAMES[i].flags;
      hdr_res.seq_num = DIRECTED_FRAMES[i].seq;
      hdr_res.body_len = DIRECTED_FRAMES[i].len;
      hdr_res.last = (DIRECTED_FRAMES[i].len == 0);
      send_frame(DIRECTED_FRAMES[i], DIRECTED_TYPED[i], hdr_res);
    end

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      apply_setting(p);
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) send_frame(random_frame(), 1'b0, '0);
    end

    // One broken header ends decoding for good; later fields may be bad too,
    // so the check order is exercised.
    wait_idle();
    scenario = $urandom_range(0, 4);
    if (scenario == 4) begin
      // empty type range: min above max
      t_lo = 16'($urandom_range(1, 16'hFFFF));
      write_reg(REG_TYPE_MIN, {16'($urandom), t_lo});
      write_reg(REG_TYPE_MAX, {16'($urandom), 16'($urandom_range(0, t_lo - 1))});
      @(negedge clk) cfg_we <= 1'b0;
    end
    h = random_frame();
    err_res = '0;
    err_res.kind = KIND_ERR;
    err_res.last = 1'b1;
    case (scenario)
      0: begin
        h.magic = h.magic ^ $urandom_range(1, 32'hFFFF_FFFF);
        h.version = 16'($urandom); h.len = $urandom; h.typ = 16'($urandom);
        err_res.error_code = ERR_MAGIC;
      end
      1: begin
        h.version = h.version ^ 16'($urandom_range(1, 16'hFFFF));
        h.len = $urandom; h.typ = 16'($urandom);
        err_res.error_code = ERR_VERSION;
      end
      2: begin
        h.len = $urandom_range(dec_cfg.max_body_len + 1, 32'hFFFF_FFFF);
        h.typ = 16'($urandom);
        err_res.error_code = ERR_LENGTH;
      end
      3: begin
        // range is a single value here, so one flipped bit leaves it
        h.typ = h.typ ^ (16'h1 << $urandom_range(0, 15));
        err_res.error_code = ERR_TYPE;
      end
      default: begin
        h.typ = 16'($urandom);
        err_res.error_code = ERR_TYPE;
      end
    endcase
    send_frame(h, 1'b1, err_res);
    // everything after the error must be swallowed
    for (int i = 0; i < 30; i++) send_byte(8'($urandom), 1'b0, '0);

    @(negedge clk) in_valid <= 1'b0;
    draining = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) $display("tb_length_prefixed_frame_decoder: PASS");
    else $display("tb_length_prefixed_frame_decoder: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lpfd_pkg.sv
rtl/core/lpfd_front.sv
rtl/core/lpfd_queue.sv
rtl/core/lpfd_back.sv
rtl/core/length_prefixed_frame_decoder.sv
bench/tb_length_prefixed_frame_decoder.sv
